// ===== sv/bvm_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the battery voltage monitor
// no dependencies; used by every module of the block

package bvm_pkg;

   // millivolt fields and result fields
   localparam int MV_W    = 13;
   localparam int BAR_W   = 3;
   localparam int COLOR_W = 2;
   localparam int INDEX_W = 3;

   // register indexes
   localparam logic [INDEX_W-1:0] CSR_LOW_CUTOFF = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_FULL_BAR   = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_THREE_BAR  = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_TWO_BAR    = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_WARN_BAR   = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_FAST_POLL  = 3'd5;

   // register reset values
   localparam logic [MV_W-1:0] LOW_CUTOFF_RST = 13'd3000;
   localparam logic [MV_W-1:0] FULL_BAR_RST   = 13'd3750;
   localparam logic [MV_W-1:0] THREE_BAR_RST  = 13'd3550;
   localparam logic [MV_W-1:0] TWO_BAR_RST    = 13'd3350;
   localparam logic [MV_W-1:0] WARN_BAR_RST   = 13'd3100;
   localparam logic [MV_W-1:0] FAST_POLL_RST  = 13'd3200;

   // fast poll never asserts at or below this floor
   localparam logic [MV_W-1:0] FAST_POLL_FLOOR_MV = 13'd500;

   // bar colors
   localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd0;
   localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd1;
   localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd2;
   localparam logic [COLOR_W-1:0] COLOR_OFF    = 2'd3;

   // bar levels
   localparam logic [BAR_W-1:0] BARS_ONE   = 3'd1;
   localparam logic [BAR_W-1:0] BARS_TWO   = 3'd2;
   localparam logic [BAR_W-1:0] BARS_THREE = 3'd3;
   localparam logic [BAR_W-1:0] BARS_FOUR  = 3'd4;

   // per-item flags carried down the pipe
   typedef struct packed {
      logic on_charger;
      logic dim_window;
      logic blink_phase;
   } flags_type;

   // threshold register file
   typedef struct packed {
      logic [MV_W-1:0] low_cutoff_mv;
      logic [MV_W-1:0] full_bar_mv;
      logic [MV_W-1:0] three_bar_mv;
      logic [MV_W-1:0] two_bar_mv;
      logic [MV_W-1:0] warn_bar_mv;
      logic [MV_W-1:0] fast_poll_mv;
   } thresholds_type;

endpackage

// ===== sv/battery_voltage_monitor_core.sv =====
`timescale 1ns / 1ps
// battery voltage monitor, top level
// depends on bvm_pkg, bvm_csr, bvm_window, bvm_divide, bvm_classify
//
// Usage:
//   req_ channel: one voltage sample in millivolts plus charger, dim window
//   and blink phase flags per transfer. rsp_ channel: one result per sample
//   with the moving average of the last WINDOW_LEN samples, bar level and
//   color, the sticky low battery flag and the fast poll flag.
//   csr_ channel: threshold writes by index, always ready; write only while
//   the block is idle.
//   The pipe has 3 register stages: running total update, reciprocal
//   multiply for the average, then classify into the result register.
//   Throughput is one sample per cycle while the receiver keeps rsp_ready
//   high; the running total is a single add and subtract per sample and
//   each stage holds one item.
//   Reset clears the sample history and running total to zero, restores
//   the threshold defaults and clears the low battery latch, which nothing
//   else clears. The first WINDOW_LEN-1 averages include the zeroed history.
//   When the receiver stalls, each stage fills in turn; req_ready drops
//   only once all three stages hold items and rsp_ready is low.

module battery_voltage_monitor_core #(
   parameter int WINDOW_LEN = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bvm_pkg::MV_W-1:0]     req_sample_mv,
   input  logic                         req_on_charger,
   input  logic                         req_dim_window,
   input  logic                         req_blink_phase,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bvm_pkg::MV_W-1:0]     rsp_average_mv,
   output logic [bvm_pkg::BAR_W-1:0]    rsp_bar_count,
   output logic [bvm_pkg::COLOR_W-1:0]  rsp_bar_color,
   output logic                         rsp_battery_low,
   output logic                         rsp_poll_fast,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bvm_pkg::INDEX_W-1:0]  csr_index,
   input  logic [bvm_pkg::MV_W-1:0]     csr_data
);

   localparam int TOTAL_W = $clog2(WINDOW_LEN * 8191 + 1);

   bvm_pkg::thresholds_type   thresholds;
   bvm_pkg::flags_type        req_flags;
   bvm_pkg::flags_type        win_flags;
   bvm_pkg::flags_type        div_flags;
   logic                      win_valid;
   logic                      win_ready;
   logic [TOTAL_W-1:0]        win_total;
   logic                      div_valid;
   logic                      div_ready;
   logic [bvm_pkg::MV_W-1:0]  div_average;

   assign req_flags.on_charger  = req_on_charger;
   assign req_flags.dim_window  = req_dim_window;
   assign req_flags.blink_phase = req_blink_phase;

   // threshold registers
   bvm_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .thresholds (thresholds)
   );

   // sample history and running total
   bvm_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .sample_mv (req_sample_mv),
      .in_flags  (req_flags),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .total     (win_total),
      .out_flags (win_flags)
   );

   // moving average
   bvm_divide #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_divide (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (win_valid),
      .in_ready   (win_ready),
      .total      (win_total),
      .in_flags   (win_flags),
      .out_valid  (div_valid),
      .out_ready  (div_ready),
      .average_mv (div_average),
      .out_flags  (div_flags)
   );

   // indicator decode and result register
   bvm_classify u_classify (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (div_valid),
      .in_ready        (div_ready),
      .average_mv      (div_average),
      .in_flags        (div_flags),
      .thresholds      (thresholds),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_average_mv  (rsp_average_mv),
      .rsp_bar_count   (rsp_bar_count),
      .rsp_bar_color   (rsp_bar_color),
      .rsp_battery_low (rsp_battery_low),
      .rsp_poll_fast   (rsp_poll_fast)
   );

   // the low latch never falls outside reset
   assert property (@(posedge clock) disable iff (reset)
      rsp_battery_low |=> rsp_battery_low)
      else $error("low battery latch cleared without reset");

   // input backpressure only comes from a stalled full pipe
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && win_valid && div_valid))
      else $error("req_ready low with room in the pipe");

   // dark blink phase shows a single bar
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_bar_color == bvm_pkg::COLOR_OFF))
         |-> (rsp_bar_count == bvm_pkg::BARS_ONE))
      else $error("blank color with more than one bar");

   // fast poll needs an average above the floor
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_poll_fast) |-> (rsp_average_mv > bvm_pkg::FAST_POLL_FLOOR_MV))
      else $error("fast poll at or below floor");

endmodule

// ===== sv/bvm_csr.sv =====
`timescale 1ns / 1ps
// threshold register file with its own write channel
// depends on bvm_pkg

module bvm_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bvm_pkg::INDEX_W-1:0]  csr_index,
   input  logic [bvm_pkg::MV_W-1:0]     csr_data,
   output bvm_pkg::thresholds_type      thresholds
);

   bvm_pkg::thresholds_type regs_ff;
   bvm_pkg::thresholds_type regs_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // decode the write, unknown indexes leave everything alone
   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         case (csr_index)
            bvm_pkg::CSR_LOW_CUTOFF: regs_in.low_cutoff_mv = csr_data;
            bvm_pkg::CSR_FULL_BAR:   regs_in.full_bar_mv   = csr_data;
            bvm_pkg::CSR_THREE_BAR:  regs_in.three_bar_mv  = csr_data;
            bvm_pkg::CSR_TWO_BAR:    regs_in.two_bar_mv    = csr_data;
            bvm_pkg::CSR_WARN_BAR:   regs_in.warn_bar_mv   = csr_data;
            bvm_pkg::CSR_FAST_POLL:  regs_in.fast_poll_mv  = csr_data;
            default:                 regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.low_cutoff_mv <= bvm_pkg::LOW_CUTOFF_RST;
         regs_ff.full_bar_mv   <= bvm_pkg::FULL_BAR_RST;
         regs_ff.three_bar_mv  <= bvm_pkg::THREE_BAR_RST;
         regs_ff.two_bar_mv    <= bvm_pkg::TWO_BAR_RST;
         regs_ff.warn_bar_mv   <= bvm_pkg::WARN_BAR_RST;
         regs_ff.fast_poll_mv  <= bvm_pkg::FAST_POLL_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign thresholds = regs_ff;

endmodule

// ===== sv/bvm_window.sv =====
`timescale 1ns / 1ps
// sample shift line and running total, first pipeline stage
// depends on bvm_pkg

module bvm_window #(
   parameter int WINDOW_LEN = 8,
   localparam int TOTAL_W = $clog2(WINDOW_LEN * 8191 + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [bvm_pkg::MV_W-1:0]  sample_mv,
   input  bvm_pkg::flags_type        in_flags,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [TOTAL_W-1:0]        total,
   output bvm_pkg::flags_type        out_flags
);

   logic [bvm_pkg::MV_W-1:0] ring_ff [WINDOW_LEN];
   logic [TOTAL_W-1:0]       total_ff;
   logic [TOTAL_W-1:0]       total_in;
   logic                     valid_ff;
   bvm_pkg::flags_type       flags_ff;
   logic                     load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // new sample in, oldest sample out
   assign total_in = total_ff - TOTAL_W'(ring_ff[WINDOW_LEN-1]) + TOTAL_W'(sample_mv);

   // shift line, the last tap is the oldest sample
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            ring_ff[i] <= '0;
         end
         total_ff <= '0;
      end else if (load) begin
         ring_ff[0] <= sample_mv;
         for (int i = 1; i < WINDOW_LEN; i++) begin
            ring_ff[i] <= ring_ff[i-1];
         end
         total_ff <= total_in;
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // flags travel with the item
   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign total     = total_ff;
   assign out_flags = flags_ff;

endmodule

// ===== sv/bvm_divide.sv =====
`timescale 1ns / 1ps
// average by reciprocal multiply, second pipeline stage
// depends on bvm_pkg

module bvm_divide #(
   parameter int WINDOW_LEN = 8,
   localparam int TOTAL_W = $clog2(WINDOW_LEN * 8191 + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [TOTAL_W-1:0]        total,
   input  bvm_pkg::flags_type        in_flags,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [bvm_pkg::MV_W-1:0]  average_mv,
   output bvm_pkg::flags_type        out_flags
);

   // floor(total / WINDOW_LEN) == (total * RECIP) >> SHIFT, exact for all totals
   localparam int      LOG_N  = $clog2(WINDOW_LEN);
   localparam int      SHIFT  = TOTAL_W + LOG_N;
   localparam longint  RECIP  = ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int      RECIP_W = SHIFT - LOG_N + 2;
   localparam int      PROD_W = TOTAL_W + RECIP_W;

   logic [RECIP_W-1:0]        recip;
   logic [PROD_W-1:0]         product;
   logic [bvm_pkg::MV_W-1:0]  avg_ff;
   logic                      valid_ff;
   bvm_pkg::flags_type        flags_ff;
   logic                      load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   assign recip   = RECIP_W'(RECIP);
   assign product = PROD_W'(total) * PROD_W'(recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // quotient and flags
   always_ff @(posedge clock) begin
      if (load) begin
         avg_ff   <= product[SHIFT +: bvm_pkg::MV_W];
         flags_ff <= in_flags;
      end
   end

   assign out_valid  = valid_ff;
   assign average_mv = avg_ff;
   assign out_flags  = flags_ff;

endmodule

// ===== sv/bvm_classify.sv =====
`timescale 1ns / 1ps
// bar level, color, poll flag and sticky low latch, result register
// depends on bvm_pkg

module bvm_classify (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [bvm_pkg::MV_W-1:0]     average_mv,
   input  bvm_pkg::flags_type           in_flags,
   input  bvm_pkg::thresholds_type      thresholds,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bvm_pkg::MV_W-1:0]     rsp_average_mv,
   output logic [bvm_pkg::BAR_W-1:0]    rsp_bar_count,
   output logic [bvm_pkg::COLOR_W-1:0]  rsp_bar_color,
   output logic                         rsp_battery_low,
   output logic                         rsp_poll_fast
);

   logic                         valid_ff;
   logic [bvm_pkg::MV_W-1:0]     avg_ff;
   logic [bvm_pkg::BAR_W-1:0]    bars_ff;
   logic [bvm_pkg::BAR_W-1:0]    bars_in;
   logic [bvm_pkg::COLOR_W-1:0]  color_ff;
   logic [bvm_pkg::COLOR_W-1:0]  color_in;
   logic                         low_ff;
   logic                         low_in;
   logic                         poll_ff;
   logic                         poll_in;
   logic                         load;

   assign in_ready = !valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;

   // thresholds checked from the top down, first hit wins
   always_comb begin
      if (average_mv >= thresholds.full_bar_mv) begin
         bars_in  = bvm_pkg::BARS_FOUR;
         color_in = bvm_pkg::COLOR_GREEN;
      end else if (average_mv >= thresholds.three_bar_mv) begin
         bars_in  = bvm_pkg::BARS_THREE;
         color_in = bvm_pkg::COLOR_GREEN;
      end else if (average_mv >= thresholds.two_bar_mv) begin
         bars_in  = bvm_pkg::BARS_TWO;
         color_in = bvm_pkg::COLOR_GREEN;
      end else if (average_mv >= thresholds.warn_bar_mv) begin
         bars_in  = bvm_pkg::BARS_ONE;
         color_in = bvm_pkg::COLOR_YELLOW;
      end else begin
         bars_in  = bvm_pkg::BARS_ONE;
         color_in = in_flags.blink_phase ? bvm_pkg::COLOR_RED : bvm_pkg::COLOR_OFF;
      end
   end

   // low latch sets only off charger inside the dim window
   assign low_in = low_ff
                   || ((average_mv <= thresholds.low_cutoff_mv)
                       && !in_flags.on_charger && in_flags.dim_window);

   assign poll_in = (average_mv < thresholds.fast_poll_mv)
                    && (average_mv > bvm_pkg::FAST_POLL_FLOOR_MV);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         low_ff   <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (load) begin
            low_ff <= low_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         avg_ff   <= average_mv;
         bars_ff  <= bars_in;
         color_ff <= color_in;
         poll_ff  <= poll_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_average_mv  = avg_ff;
   assign rsp_bar_count   = bars_ff;
   assign rsp_bar_color   = color_ff;
   assign rsp_battery_low = low_ff;
   assign rsp_poll_fast   = poll_ff;

endmodule

// ===== tb/battery_voltage_monitor_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for battery_voltage_monitor_core
// depends on bvm_pkg and the battery voltage monitor RTL

module battery_voltage_monitor_core_tb;
   import bvm_pkg::*;

   localparam int WINDOW_LEN  = 8;
   localparam int MV_MAX      = 8191;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 100;
   localparam int TAIL_CYCLES = 8;

   // indexes past the register file, writes there must be dropped
   localparam logic [INDEX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [INDEX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   typedef enum {
      SET_NOMINAL,
      SET_ZERO,
      SET_FULL_SCALE,
      SET_ORDERED,
      SET_SCRAMBLED
   } setting_type;

   // moving average gauge: predicts one reading per sample, checks in order
   class gauge_predictor;
      typedef struct {
         logic [MV_W-1:0]    average_mv;
         logic [BAR_W-1:0]   bar_count;
         logic [COLOR_W-1:0] bar_color;
         logic               battery_low;
         logic               poll_fast;
      } reading_type;

      logic [MV_W-1:0] history[WINDOW_LEN];
      int              slot;
      logic [15:0]     total;
      logic            low_latched;
      thresholds_type  thr;
      reading_type     pending_readings[$];
      int              mismatches;
      int              checked;
      int              low_seen;
      int              fast_seen;

      function new();
         foreach (history[i]) history[i] = '0;
         slot        = 0;
         total       = '0;
         low_latched = 1'b0;
         thr.low_cutoff_mv = LOW_CUTOFF_RST;
         thr.full_bar_mv   = FULL_BAR_RST;
         thr.three_bar_mv  = THREE_BAR_RST;
         thr.two_bar_mv    = TWO_BAR_RST;
         thr.warn_bar_mv   = WARN_BAR_RST;
         thr.fast_poll_mv  = FAST_POLL_RST;
         mismatches = 0;
         checked    = 0;
         low_seen   = 0;
         fast_seen  = 0;
      endfunction

      // register write, unknown indexes are dropped
      function void apply_write(logic [INDEX_W-1:0] index, logic [MV_W-1:0] data);
         case (index)
            CSR_LOW_CUTOFF: thr.low_cutoff_mv = data;
            CSR_FULL_BAR:   thr.full_bar_mv   = data;
            CSR_THREE_BAR:  thr.three_bar_mv  = data;
            CSR_TWO_BAR:    thr.two_bar_mv    = data;
            CSR_WARN_BAR:   thr.warn_bar_mv   = data;
            CSR_FAST_POLL:  thr.fast_poll_mv  = data;
            default: ;
         endcase
      endfunction

      // accepted sample: update window and latch, queue the reading
      function void note_sample(logic [MV_W-1:0] mv, logic charging, logic dim, logic lit);
         reading_type r;
         logic [MV_W-1:0] avg;
         total = total - 16'(history[slot]) + 16'(mv);
         history[slot] = mv;
         slot = (slot + 1) % WINDOW_LEN;
         avg = MV_W'(total / 16'(WINDOW_LEN));

         // sticky low flag, only reset clears it
         if (avg <= thr.low_cutoff_mv && !charging && dim) low_latched = 1'b1;

         // fixed priority: full, three, two, warn
         if (avg >= thr.full_bar_mv) begin
            r.bar_count = BARS_FOUR;
            r.bar_color = COLOR_GREEN;
         end else if (avg >= thr.three_bar_mv) begin
            r.bar_count = BARS_THREE;
            r.bar_color = COLOR_GREEN;
         end else if (avg >= thr.two_bar_mv) begin
            r.bar_count = BARS_TWO;
            r.bar_color = COLOR_GREEN;
         end else if (avg >= thr.warn_bar_mv) begin
            r.bar_count = BARS_ONE;
            r.bar_color = COLOR_YELLOW;
         end else begin
            r.bar_count = BARS_ONE;
            r.bar_color = lit ? COLOR_RED : COLOR_OFF;
         end

         r.average_mv  = avg;
         r.battery_low = low_latched;
         r.poll_fast   = (avg < thr.fast_poll_mv) && (avg > FAST_POLL_FLOOR_MV);
         pending_readings.push_back(r);
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      // result transfer: compare with the oldest queued reading
      task check_reading(input logic [MV_W-1:0] avg, input logic [BAR_W-1:0] bars,
                         input logic [COLOR_W-1:0] color, input logic low,
                         input logic fast);
         reading_type want;
         if (pending_readings.size() == 0) begin
            report_mismatch("reading with no sample outstanding");
            return;
         end
         want = pending_readings.pop_front();
         checked++;
         if (low) low_seen++;
         if (fast) fast_seen++;
         if (avg !== want.average_mv)
            report_mismatch($sformatf("average_mv got %0d want %0d", avg, want.average_mv));
         if (bars !== want.bar_count)
            report_mismatch($sformatf("bar_count got %0d want %0d (avg %0d)",
                                      bars, want.bar_count, want.average_mv));
         if (color !== want.bar_color)
            report_mismatch($sformatf("bar_color got %0d want %0d (avg %0d)",
                                      color, want.bar_color, want.average_mv));
         if (low !== want.battery_low)
            report_mismatch($sformatf("battery_low got %0b want %0b (avg %0d)",
                                      low, want.battery_low, want.average_mv));
         if (fast !== want.poll_fast)
            report_mismatch($sformatf("poll_fast got %0b want %0b (avg %0d)",
                                      fast, want.poll_fast, want.average_mv));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [MV_W-1:0]    req_sample_mv;
   logic               req_on_charger;
   logic               req_dim_window;
   logic               req_blink_phase;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [MV_W-1:0]    rsp_average_mv;
   logic [BAR_W-1:0]   rsp_bar_count;
   logic [COLOR_W-1:0] rsp_bar_color;
   logic               rsp_battery_low;
   logic               rsp_poll_fast;
   logic               csr_valid;
   logic               csr_ready;
   logic [INDEX_W-1:0] csr_index;
   logic [MV_W-1:0]    csr_data;

   gauge_predictor predictor = new();
   int idle_cycles = 0;
   int settings_run = 0;
   bit no_idle = 1'b0;

   battery_voltage_monitor_core #(
      .WINDOW_LEN(WINDOW_LEN)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_mv   (req_sample_mv),
      .req_on_charger  (req_on_charger),
      .req_dim_window  (req_dim_window),
      .req_blink_phase (req_blink_phase),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_average_mv  (rsp_average_mv),
      .rsp_bar_count   (rsp_bar_count),
      .rsp_bar_color   (rsp_bar_color),
      .rsp_battery_low (rsp_battery_low),
      .rsp_poll_fast   (rsp_poll_fast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // monitor: every transfer seen at the edge goes to the predictor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            predictor.note_sample(req_sample_mv, req_on_charger, req_dim_window,
                                  req_blink_phase);
         if (rsp_valid && rsp_ready)
            predictor.check_reading(rsp_average_mv, rsp_bar_count, rsp_bar_color,
                                    rsp_battery_low, rsp_poll_fast);
         if (csr_valid && csr_ready) predictor.apply_write(csr_index, csr_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: random stalls, an occasional long one to back up the pipe
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset || no_idle) begin
            rsp_ready <= !reset;
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(3, 9)) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 11);
         end
      end
   end

   function automatic logic [MV_W-1:0] clamp_mv(input int v);
      if (v < 0) return '0;
      if (v > MV_MAX) return MV_W'(MV_MAX);
      return MV_W'(v);
   endfunction

   // one sample transfer, sometimes preceded by a random sender gap
   task automatic drive_sample(input logic [MV_W-1:0] mv, input logic ch, input logic dim,
                               input logic blink);
      if (!no_idle && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_mv   <= mv;
      req_on_charger  <= ch;
      req_dim_window  <= dim;
      req_blink_phase <= blink;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // random sample around a target; guard keeps the low latch from setting
   task automatic drive_random(input int target, input int amp, input bit guard);
      int   v;
      logic ch;
      logic dim;
      if ($urandom_range(0, 99) < 12) v = int'($urandom_range(0, MV_MAX));
      else v = target + int'($urandom_range(0, 2 * amp)) - amp;
      ch  = 1'($urandom_range(0, 1));
      dim = 1'($urandom_range(0, 1));
      if (guard && !ch && dim) begin
         if ($urandom_range(0, 1) == 1) ch = 1'b1;
         else dim = 1'b0;
      end
      drive_sample(clamp_mv(v), ch, dim, 1'($urandom_range(0, 1)));
   endtask

   // stop sending and wait until every reading has come back
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predictor.pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [INDEX_W-1:0] index,
                                  input logic [MV_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // write all six thresholds for one setting, optionally also the unmapped indexes
   task automatic program_thresholds(input setting_type kind, input bit with_unmapped);
      thresholds_type t;
      case (kind)
         SET_NOMINAL: begin
            t.low_cutoff_mv = LOW_CUTOFF_RST;
            t.full_bar_mv   = FULL_BAR_RST;
            t.three_bar_mv  = THREE_BAR_RST;
            t.two_bar_mv    = TWO_BAR_RST;
            t.warn_bar_mv   = WARN_BAR_RST;
            t.fast_poll_mv  = FAST_POLL_RST;
         end
         SET_ZERO:       t = '0;
         SET_FULL_SCALE: t = '1;
         SET_ORDERED: begin
            t.low_cutoff_mv = MV_W'($urandom_range(600, 6800));
            t.warn_bar_mv   = t.low_cutoff_mv + MV_W'($urandom_range(20, 300));
            t.two_bar_mv    = t.warn_bar_mv + MV_W'($urandom_range(20, 300));
            t.three_bar_mv  = t.two_bar_mv + MV_W'($urandom_range(20, 300));
            t.full_bar_mv   = t.three_bar_mv + MV_W'($urandom_range(20, 300));
            t.fast_poll_mv  = MV_W'($urandom_range(t.low_cutoff_mv, t.two_bar_mv));
         end
         default: begin
            t.low_cutoff_mv = MV_W'($urandom_range(0, MV_MAX));
            t.full_bar_mv   = MV_W'($urandom_range(0, MV_MAX));
            t.three_bar_mv  = MV_W'($urandom_range(0, MV_MAX));
            t.two_bar_mv    = MV_W'($urandom_range(0, MV_MAX));
            t.warn_bar_mv   = MV_W'($urandom_range(0, MV_MAX));
            t.fast_poll_mv  = MV_W'($urandom_range(0, MV_MAX));
         end
      endcase
      write_threshold(CSR_LOW_CUTOFF, t.low_cutoff_mv);
      write_threshold(CSR_FULL_BAR, t.full_bar_mv);
      write_threshold(CSR_THREE_BAR, t.three_bar_mv);
      write_threshold(CSR_TWO_BAR, t.two_bar_mv);
      write_threshold(CSR_WARN_BAR, t.warn_bar_mv);
      write_threshold(CSR_FAST_POLL, t.fast_poll_mv);
      if (with_unmapped) begin
         write_threshold(CSR_UNMAPPED_LO, MV_W'($urandom_range(0, MV_MAX)));
         write_threshold(CSR_UNMAPPED_HI, MV_W'($urandom_range(0, MV_MAX)));
      end
      settings_run++;
   endtask

   // burst target: a threshold, the poll floor, a rail or anywhere
   function automatic int pick_target();
      int base;
      case ($urandom_range(0, 9))
         0:       base = int'(predictor.thr.low_cutoff_mv);
         1:       base = int'(predictor.thr.full_bar_mv);
         2:       base = int'(predictor.thr.three_bar_mv);
         3:       base = int'(predictor.thr.two_bar_mv);
         4:       base = int'(predictor.thr.warn_bar_mv);
         5:       base = int'(predictor.thr.fast_poll_mv);
         6:       base = int'(FAST_POLL_FLOOR_MV);
         7:       base = 0;
         8:       base = MV_MAX;
         default: base = int'($urandom_range(0, MV_MAX));
      endcase
      if ($urandom_range(0, 2) != 0) base = base + int'($urandom_range(0, 2)) - 1;
      return base;
   endfunction

   // main stimulus
   initial begin
      int          i;
      int          phase;
      int          items;
      int          len;
      int          target;
      int          amp;
      setting_type kind;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_sample_mv   <= '0;
      req_on_charger  <= 1'b0;
      req_dim_window  <= 1'b0;
      req_blink_phase <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= '0;
      csr_data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: warm-up from zero history while charging, dark phase
      drive_sample('0, 1'b1, 1'b1, 1'b0);
      drive_sample('0, 1'b0, 1'b0, 1'b1);
      // ramp to full scale, average climbs from the lowest bar level to four bars
      for (i = 0; i < WINDOW_LEN; i++)
         drive_sample(MV_W'(MV_MAX), 1'(i), 1'(i) & 1'(i >> 1), 1'(i >> 1));
      // settle exactly on the default four bar threshold
      for (i = 0; i < WINDOW_LEN; i++)
         drive_sample(MV_W'(FULL_BAR_RST), 1'b1, 1'(i), 1'(i));
      // drop below the cutoff with the latch condition not met
      drive_sample('0, 1'b1, 1'b1, 1'b0);
      drive_sample('0, 1'b0, 1'b0, 1'b1);
      drive_sample('0, 1'b1, 1'b0, 1'b0);
      drive_sample(MV_W'(MV_MAX), 1'b0, 1'b0, 1'b1);

      // random phases, one threshold setting each
      for (phase = 0; phase < PHASES; phase++) begin
         drain_pipe();
         case (phase)
            0:       kind = SET_ORDERED;
            1, 10:   kind = SET_ZERO;
            2, 11:   kind = SET_FULL_SCALE;
            3:       kind = SET_SCRAMBLED;
            5:       kind = SET_NOMINAL;
            default: kind = ($urandom_range(0, 2) == 0) ? SET_SCRAMBLED : SET_ORDERED;
         endcase
         program_thresholds(kind, (phase % 3) == 0);
         no_idle = (phase == 4);
         items = 0;
         while (items < PHASE_ITEMS) begin
            target = pick_target();
            case ($urandom_range(0, 3))
               0:       amp = 0;
               1:       amp = 2;
               2:       amp = 30;
               default: amp = 600;
            endcase
            len = int'($urandom_range(8, 20));
            for (i = 0; i < len && items < PHASE_ITEMS; i++) begin
               // early phases keep the low latch clear
               drive_random(target, amp, phase < 6);
               items++;
               if (phase == 3 && items == PHASE_ITEMS / 2) drain_pipe();
            end
         end
      end
      no_idle = 1'b0;

      // drain and let the pipe run empty
      drain_pipe();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (predictor.pending_readings.size() != 0)
         predictor.report_mismatch($sformatf("%0d readings never arrived",
                                             predictor.pending_readings.size()));

      $display("covered %0d readings over %0d threshold settings plus reset defaults",
               predictor.checked, settings_run);
      $display("low flag held in %0d readings, fast poll in %0d, %0d mismatches",
               predictor.low_seen, predictor.fast_seen, predictor.mismatches);
      if (predictor.mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
